>>> src/region_boundary_tracer_defines.svh
// ----------------------------------------------------------------------------
// Region boundary tracer assertion macros
// Shared property shorthands for the block's checker.
// ----------------------------------------------------------------------------
`ifndef REGION_BOUNDARY_TRACER_DEFINES_SVH
`define REGION_BOUNDARY_TRACER_DEFINES_SVH

// Same-cycle implication.
`define RBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbt check failed");

// Next-cycle implication.
`define RBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbt check failed");

`endif

>>> src/rbt_pkg.sv
// ----------------------------------------------------------------------------
// Region boundary tracer package
// Sizes, operation codes, register indexes and walk direction helpers.
// ----------------------------------------------------------------------------
package rbt_pkg;

   localparam int unsigned MAX_SIDE    = 256;
   localparam int unsigned COORD_W     = 8;
   localparam int unsigned SIDE_W      = 9;
   localparam int unsigned ADDR_W      = 2 * COORD_W;
   localparam int unsigned COLOR_W     = 32;
   localparam int unsigned COUNT_W     = 17;
   localparam int unsigned EPOCH_W     = 8;
   localparam int unsigned CSR_ADDR_W  = 3;

   localparam logic [COUNT_W-1:0] POINT_LIMIT = 17'd65536;
   localparam logic [SIDE_W-1:0]  SIDE_MAX    = 9'd256;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

   localparam logic [2:0] PRB_CENTER = 3'd0;
   localparam logic [2:0] PRB_LEFT   = 3'd1;
   localparam logic [2:0] PRB_RIGHT  = 3'd2;
   localparam logic [2:0] PRB_UP     = 3'd3;
   localparam logic [2:0] PRB_DOWN   = 3'd4;

   typedef enum logic [1:0] {STEP_NONE, STEP_INC, STEP_DEC} step_type;

   function automatic step_type step_dx(input logic [2:0] dir);
      case (dir)
         3'd0, 3'd6, 3'd7: step_dx = STEP_DEC;
         3'd2, 3'd3, 3'd4: step_dx = STEP_INC;
         default:          step_dx = STEP_NONE;
      endcase
   endfunction

   function automatic step_type step_dy(input logic [2:0] dir);
      case (dir)
         3'd0, 3'd1, 3'd2: step_dy = STEP_DEC;
         3'd4, 3'd5, 3'd6: step_dy = STEP_INC;
         default:          step_dy = STEP_NONE;
      endcase
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [31:0] v);
      if (v == 32'd0) begin
         clamp_side = 9'd1;
      end else if (v > 32'(SIDE_MAX)) begin
         clamp_side = SIDE_MAX;
      end else begin
         clamp_side = v[SIDE_W-1:0];
      end
   endfunction

endpackage

>>> src/rbt_channels.sv
// ----------------------------------------------------------------------------
// Region boundary tracer channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface rbt_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [31:0] pixel_color;
   modport source (output valid, operation, pixel_x, pixel_y, pixel_color, input ready);
   modport sink   (input valid, operation, pixel_x, pixel_y, pixel_color, output ready);
endinterface

interface rbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  point_x;
   logic [7:0]  point_y;
   logic        contour_start;
   logic        done_res;
   logic [8:0]  bbox_min_x;
   logic [8:0]  bbox_min_y;
   logic [7:0]  bbox_max_x;
   logic [7:0]  bbox_max_y;
   logic [16:0] point_count;
   modport source (output valid, point_x, point_y, contour_start, done_res, bbox_min_x,
                   bbox_min_y, bbox_max_x, bbox_max_y, point_count, input ready);
   modport sink   (input valid, point_x, point_y, contour_start, done_res, bbox_min_x,
                   bbox_min_y, bbox_max_x, bbox_max_y, point_count, output ready);
endinterface

>>> src/rbt_ram.sv
// ----------------------------------------------------------------------------
// Region boundary tracer RAM
// Simple dual-port memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> src/region_boundary_tracer.sv
// A write request stores one label. A fetch request reads labels one at a time; a scanned
// pixel is checked against its neighbours, a walk step marks a point and then tries up to 8 neighbours.
// The single read port of the label memory sets the pace; one request at a time.
// Reset is synchronous; afterwards a clearing pass over the whole visited
// memory runs, and again after every 255th restart that follows marked points.
// ----------------------------------------------------------------------------
// Region boundary tracer
// Label image store with raster scan and eight-direction contour walk.
// ----------------------------------------------------------------------------
module region_boundary_tracer (
   input  logic                           clock,
   input  logic                           reset,
   rbt_req_if.sink                        req_chan,
   rbt_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rbt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import rbt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_SCAN, S_PROBE_RD, S_PROBE_CHK, S_MARK, S_DIR, S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [SIDE_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic                 dirty_ff, dirty_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [COORD_W-1:0]   scan_x_ff, scan_x_in;
   logic [SIDE_W-1:0]    scan_y_ff, scan_y_in;
   logic [COORD_W-1:0]   walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic [COLOR_W-1:0]   walk_color_ff, walk_color_in;
   logic                 walking_ff, walking_in;
   logic [SIDE_W-1:0]    min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic [COORD_W-1:0]   max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COORD_W-1:0]   probe_x_ff, probe_x_in, probe_y_ff, probe_y_in;
   logic [COLOR_W-1:0]   probe_color_ff, probe_color_in;
   logic [2:0]           probe_k_ff, probe_k_in;
   logic                 probe_scan_ff, probe_scan_in;
   logic [3:0]           dir_ff, dir_in;
   logic [COORD_W-1:0]   res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                 res_start_ff, res_start_in, res_done_ff, res_done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                 rsp_start_ff, rsp_start_in, rsp_done_ff, rsp_done_in;
   logic [SIDE_W-1:0]    rsp_min_x_ff, rsp_min_x_in, rsp_min_y_ff, rsp_min_y_in;
   logic [COORD_W-1:0]   rsp_max_x_ff, rsp_max_x_in, rsp_max_y_ff, rsp_max_y_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 lbl_we;
   logic [ADDR_W-1:0]    lbl_waddr, lbl_raddr;
   logic [COLOR_W-1:0]   lbl_rdata;
   logic                 vis_we;
   logic [ADDR_W-1:0]    vis_waddr;
   logic [EPOCH_W-1:0]   vis_wdata, vis_rdata;

   logic                 req_fire, cfg_wr, restart, on_edge, oob, pass, fail;
   logic [COORD_W-1:0]   rd_x, rd_y, nx, ny;
   logic [COLOR_W-1:0]   cmp_color;
   step_type             sx, sy;

   rbt_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_SIDE * MAX_SIDE)) u_label_ram (
      .clock(clock), .we(lbl_we), .waddr(lbl_waddr), .wdata(req_chan.pixel_color),
      .raddr(lbl_raddr), .rdata(lbl_rdata)
   );

   rbt_ram #(.WIDTH(EPOCH_W), .DEPTH(MAX_SIDE * MAX_SIDE)) u_visited_ram (
      .clock(clock), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
      .raddr(lbl_raddr), .rdata(vis_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign cfg_wr         = psel && penable && pwrite;
   assign pready         = 1'b1;
   assign prdata         = {23'd0, (paddr[2] == REG_HEIGHT) ? height_ff : width_ff};
   assign lbl_waddr      = {req_chan.pixel_y, req_chan.pixel_x};

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.point_x       = rsp_x_ff;
   assign rsp_chan.point_y       = rsp_y_ff;
   assign rsp_chan.contour_start = rsp_start_ff;
   assign rsp_chan.done_res      = rsp_done_ff;
   assign rsp_chan.bbox_min_x    = rsp_min_x_ff;
   assign rsp_chan.bbox_min_y    = rsp_min_y_ff;
   assign rsp_chan.bbox_max_x    = rsp_max_x_ff;
   assign rsp_chan.bbox_max_y    = rsp_max_y_ff;
   assign rsp_chan.point_count   = rsp_count_ff;

   always_comb begin
      rd_x = probe_x_ff;
      rd_y = probe_y_ff;
      case (probe_k_ff)
         PRB_LEFT:  rd_x = probe_x_ff - 8'd1;
         PRB_RIGHT: rd_x = probe_x_ff + 8'd1;
         PRB_UP:    rd_y = probe_y_ff - 8'd1;
         PRB_DOWN:  rd_y = probe_y_ff + 8'd1;
         default:   rd_x = probe_x_ff;
      endcase
      lbl_raddr = {rd_y, rd_x};

      on_edge = (probe_x_ff == 8'd0) || (probe_y_ff == 8'd0) ||
                ({1'b0, probe_x_ff} == width_ff - 9'd1) ||
                ({1'b0, probe_y_ff} == height_ff - 9'd1);
      cmp_color = (probe_scan_ff && probe_k_ff == PRB_CENTER) ? lbl_rdata : probe_color_ff;

      sx  = step_dx(dir_ff[2:0]);
      sy  = step_dy(dir_ff[2:0]);
      oob = (sx == STEP_DEC && walk_x_ff == 8'd0) ||
            (sx == STEP_INC && {1'b0, walk_x_ff} + 9'd1 == width_ff) ||
            (sy == STEP_DEC && walk_y_ff == 8'd0) ||
            (sy == STEP_INC && {1'b0, walk_y_ff} + 9'd1 == height_ff);
      nx  = (sx == STEP_INC) ? walk_x_ff + 8'd1 :
            (sx == STEP_DEC) ? walk_x_ff - 8'd1 : walk_x_ff;
      ny  = (sy == STEP_INC) ? walk_y_ff + 8'd1 :
            (sy == STEP_DEC) ? walk_y_ff - 8'd1 : walk_y_ff;
   end

   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      epoch_in       = epoch_ff;
      dirty_in       = dirty_ff;
      clr_addr_in    = clr_addr_ff;
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      walk_x_in      = walk_x_ff;
      walk_y_in      = walk_y_ff;
      walk_color_in  = walk_color_ff;
      walking_in     = walking_ff;
      min_x_in       = min_x_ff;
      min_y_in       = min_y_ff;
      max_x_in       = max_x_ff;
      max_y_in       = max_y_ff;
      count_in       = count_ff;
      probe_x_in     = probe_x_ff;
      probe_y_in     = probe_y_ff;
      probe_color_in = probe_color_ff;
      probe_k_in     = probe_k_ff;
      probe_scan_in  = probe_scan_ff;
      dir_in         = dir_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      res_start_in   = res_start_ff;
      res_done_in    = res_done_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_done_in    = rsp_done_ff;
      rsp_min_x_in   = rsp_min_x_ff;
      rsp_min_y_in   = rsp_min_y_ff;
      rsp_max_x_in   = rsp_max_x_ff;
      rsp_max_y_in   = rsp_max_y_ff;
      rsp_count_in   = rsp_count_ff;
      lbl_we         = 1'b0;
      vis_we         = 1'b0;
      vis_waddr      = {walk_y_ff, walk_x_ff};
      vis_wdata      = epoch_ff;
      restart        = 1'b0;
      pass           = 1'b0;
      fail           = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            vis_we      = 1'b1;
            vis_waddr   = clr_addr_ff;
            vis_wdata   = '0;
            clr_addr_in = clr_addr_ff + 16'd1;
            if (clr_addr_ff == '1) begin
               epoch_in = EPOCH_FIRST;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.operation == OP_WRITE) begin
                  lbl_we  = 1'b1;
                  restart = 1'b1;
               end else if (count_ff >= POINT_LIMIT) begin
                  walking_in  = 1'b0;
                  res_x_in    = '0;
                  res_y_in    = '0;
                  res_start_in = 1'b0;
                  res_done_in = 1'b1;
                  state_in    = S_OUT;
               end else if (walking_ff) begin
                  res_start_in = 1'b0;
                  state_in     = S_MARK;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_y_ff >= height_ff) begin
               res_x_in     = '0;
               res_y_in     = '0;
               res_start_in = 1'b0;
               res_done_in  = 1'b1;
               state_in     = S_OUT;
            end else begin
               probe_x_in    = scan_x_ff;
               probe_y_in    = scan_y_ff[COORD_W-1:0];
               probe_k_in    = PRB_CENTER;
               probe_scan_in = 1'b1;
               state_in      = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (probe_k_ff == PRB_CENTER) begin
               probe_color_in = cmp_color;
               if (lbl_rdata == '0 || lbl_rdata != cmp_color || vis_rdata == epoch_ff) begin
                  fail = 1'b1;
               end else if (on_edge) begin
                  pass = 1'b1;
               end else begin
                  probe_k_in = PRB_LEFT;
                  state_in   = S_PROBE_RD;
               end
            end else if (lbl_rdata != probe_color_ff) begin
               pass = 1'b1;
            end else if (probe_k_ff == PRB_DOWN) begin
               fail = 1'b1;
            end else begin
               probe_k_in = probe_k_ff + 3'd1;
               state_in   = S_PROBE_RD;
            end
            if (pass) begin
               walk_x_in = probe_x_ff;
               walk_y_in = probe_y_ff;
               if (probe_scan_ff) begin
                  walk_color_in = cmp_color;
                  walking_in    = 1'b1;
                  res_start_in  = 1'b1;
                  state_in      = S_MARK;
               end else begin
                  state_in = S_OUT;
               end
            end
            if (fail) begin
               if (probe_scan_ff) begin
                  if ({1'b0, scan_x_ff} + 9'd1 == width_ff) begin
                     scan_x_in = '0;
                     scan_y_in = scan_y_ff + 9'd1;
                  end else begin
                     scan_x_in = scan_x_ff + 8'd1;
                  end
                  state_in = S_SCAN;
               end else begin
                  dir_in   = dir_ff + 4'd1;
                  state_in = S_DIR;
               end
            end
            if (probe_scan_ff && probe_k_ff == PRB_CENTER && !pass && !fail) begin
               walk_color_in = walk_color_ff;
            end
         end
         S_MARK: begin
            vis_we      = 1'b1;
            dirty_in    = 1'b1;
            count_in    = count_ff + 17'd1;
            res_x_in    = walk_x_ff;
            res_y_in    = walk_y_ff;
            res_done_in = 1'b0;
            if ({1'b0, walk_x_ff} < min_x_ff) min_x_in = {1'b0, walk_x_ff};
            if ({1'b0, walk_y_ff} < min_y_ff) min_y_in = {1'b0, walk_y_ff};
            if (walk_x_ff > max_x_ff) max_x_in = walk_x_ff;
            if (walk_y_ff > max_y_ff) max_y_in = walk_y_ff;
            if (count_ff + 17'd1 >= POINT_LIMIT) begin
               walking_in = 1'b0;
               state_in   = S_OUT;
            end else begin
               dir_in   = '0;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            if (dir_ff[3]) begin
               walking_in = 1'b0;
               state_in   = S_OUT;
            end else if (oob) begin
               dir_in = dir_ff + 4'd1;
            end else begin
               probe_x_in     = nx;
               probe_y_in     = ny;
               probe_color_in = walk_color_ff;
               probe_k_in     = PRB_CENTER;
               probe_scan_in  = 1'b0;
               state_in       = S_PROBE_RD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_start_in = res_start_ff;
               rsp_done_in  = res_done_ff;
               rsp_min_x_in = min_x_ff;
               rsp_min_y_in = min_y_ff;
               rsp_max_x_in = max_x_ff;
               rsp_max_y_in = max_y_ff;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cfg_wr) begin
         restart = 1'b1;
         if (paddr[2] == REG_HEIGHT) begin
            height_in = clamp_side(pwdata);
         end else begin
            width_in = clamp_side(pwdata);
         end
      end

      if (restart) begin
         scan_x_in     = '0;
         scan_y_in     = '0;
         walking_in    = 1'b0;
         walk_x_in     = '0;
         walk_y_in     = '0;
         walk_color_in = '0;
         min_x_in      = width_in;
         min_y_in      = height_in;
         max_x_in      = '0;
         max_y_in      = '0;
         count_in      = '0;
         if (dirty_ff) begin
            dirty_in = 1'b0;
            if (epoch_ff == EPOCH_LAST) begin
               clr_addr_in = '0;
               state_in    = S_CLEAR;
            end else begin
               epoch_in = epoch_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         width_ff      <= SIDE_MAX;
         height_ff     <= SIDE_MAX;
         epoch_ff      <= EPOCH_FIRST;
         dirty_ff      <= 1'b0;
         clr_addr_ff   <= '0;
         scan_x_ff     <= '0;
         scan_y_ff     <= '0;
         walk_x_ff     <= '0;
         walk_y_ff     <= '0;
         walk_color_ff <= '0;
         walking_ff    <= 1'b0;
         min_x_ff      <= SIDE_MAX;
         min_y_ff      <= SIDE_MAX;
         max_x_ff      <= '0;
         max_y_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         epoch_ff      <= epoch_in;
         dirty_ff      <= dirty_in;
         clr_addr_ff   <= clr_addr_in;
         scan_x_ff     <= scan_x_in;
         scan_y_ff     <= scan_y_in;
         walk_x_ff     <= walk_x_in;
         walk_y_ff     <= walk_y_in;
         walk_color_ff <= walk_color_in;
         walking_ff    <= walking_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      probe_x_ff     <= probe_x_in;
      probe_y_ff     <= probe_y_in;
      probe_color_ff <= probe_color_in;
      probe_k_ff     <= probe_k_in;
      probe_scan_ff  <= probe_scan_in;
      dir_ff         <= dir_in;
      res_x_ff       <= res_x_in;
      res_y_ff       <= res_y_in;
      res_start_ff   <= res_start_in;
      res_done_ff    <= res_done_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_min_x_ff   <= rsp_min_x_in;
      rsp_min_y_ff   <= rsp_min_y_in;
      rsp_max_x_ff   <= rsp_max_x_in;
      rsp_max_y_ff   <= rsp_max_y_in;
      rsp_count_ff   <= rsp_count_in;
   end

endmodule

>>> src/rbt_checker.sv
// ----------------------------------------------------------------------------
// Region boundary tracer checker
// Port-level checks on the response handshake and contents, bound to the top level.
// ----------------------------------------------------------------------------
`include "region_boundary_tracer_defines.svh"

module rbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_point_x,
   input logic [7:0]  rsp_point_y,
   input logic        rsp_contour_start,
   input logic        rsp_done_res,
   input logic [8:0]  rsp_bbox_min_x,
   input logic [7:0]  rsp_bbox_max_x,
   input logic [16:0] rsp_point_count
);

   `RBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RBT_ASSERT_IMP(a_done_empty, clock, reset, rsp_valid && rsp_done_res, rsp_point_x == 8'd0 && rsp_point_y == 8'd0 && !rsp_contour_start)
   `RBT_ASSERT_IMP(a_point_counted, clock, reset, rsp_valid && !rsp_done_res, rsp_point_count != 17'd0)
   `RBT_ASSERT_IMP(a_point_in_box, clock, reset, rsp_valid && !rsp_done_res, rsp_bbox_min_x <= {1'b0, rsp_point_x} && rsp_bbox_max_x >= rsp_point_x)

endmodule

bind region_boundary_tracer rbt_checker u_rbt_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_point_x       (rsp_chan.point_x),
   .rsp_point_y       (rsp_chan.point_y),
   .rsp_contour_start (rsp_chan.contour_start),
   .rsp_done_res      (rsp_chan.done_res),
   .rsp_bbox_min_x    (rsp_chan.bbox_min_x),
   .rsp_bbox_max_x    (rsp_chan.bbox_max_x),
   .rsp_point_count   (rsp_chan.point_count)
);
